// ===== hw/rtl/bpa_pkg.sv =====
`default_nettype none

package bpa_pkg;

  // Defaults for the pool geometry
  localparam int unsigned BLOCK_BYTES_DEF = 32;
  localparam int unsigned BLOCK_COUNT_DEF = 256;

  // Fixed field widths
  localparam int unsigned REQ_W    = 20;
  localparam int unsigned OFF_W    = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned GRANT_W  = 13;
  localparam int unsigned USED_W   = 9;
  localparam int unsigned ENTRY_W  = 9;

  // Largest run length an owner entry can record
  localparam int unsigned ENTRY_MAX = 511;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    RES_OK          = 2'd0,
    RES_BAD_SIZE    = 2'd1,
    RES_NO_ROOM     = 2'd2,
    RES_OUT_OF_POOL = 2'd3
  } bpa_status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_MARK,
    ST_DIV,
    ST_FREE,
    ST_RESP
  } bpa_state_e;

  typedef struct packed {
    logic        clear_step;
    logic        load;
    logic        scan_start;
    logic        scan_step;
    logic        mark_step;
    logic        div_step;
    logic        free_step;
    logic        set_status;
    bpa_status_e status;
  } bpa_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic mode_free;
    logic bad_size;
    logic bad_off;
    logic scan_hit;
    logic scan_miss;
    logic mark_done;
    logic free_done;
  } bpa_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/block_pool_allocator_core.sv =====
// First-fit block pool allocator.
// Input channel (in_valid_i/in_ready_o): one request per transfer; mode_i
// selects allocate (request_bytes_i) or free (free_offset_i).
// Output channel (out_valid_o/out_ready_i): one result per request with
// status_o, granted_offset_o (byte offset of a granted run, else 0) and
// used_blocks_o (blocks in use after the request).
// One request is in flight at a time; the next can be taken in the cycle
// after the result transfer, not before that transfer completes.
// Allocate: the scan reads the table up to the last block of the first
// fitting run, then marks that run's blocks; a failed scan reads every entry.
// The owner table is read once per cycle through its single read port, so
// the scan dominates. Rejected requests go from the check to the response.
// Free: the offset is turned into a block index by a constant reciprocal
// multiply, then the run's blocks are cleared one per cycle.
// Reset: the owner table is cleared one entry per cycle, with in_ready_o
// low until that pass is done.
// A stalled receiver holds the result in the output register and the block
// takes no new request until that transfer completes.
`default_nettype none

module block_pool_allocator_core #(
  parameter int unsigned BLOCK_BYTES = bpa_pkg::BLOCK_BYTES_DEF,
  parameter int unsigned BLOCK_COUNT = bpa_pkg::BLOCK_COUNT_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        mode_i,
  input  wire logic [bpa_pkg::REQ_W-1:0]   request_bytes_i,
  input  wire logic [bpa_pkg::OFF_W-1:0]   free_offset_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [bpa_pkg::STATUS_W-1:0]     status_o,
  output logic [bpa_pkg::GRANT_W-1:0]      granted_offset_o,
  output logic [bpa_pkg::USED_W-1:0]       used_blocks_o
);
  import bpa_pkg::*;

  // command and status between the sequencer and the table datapath
  bpa_cmd_t cmd;
  bpa_sts_t sts;

  bpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // owner table, scan/free counters, index conversion and result registers
  bpa_dp #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .BLOCK_COUNT (BLOCK_COUNT)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .mode_i           (mode_i),
    .request_bytes_i  (request_bytes_i),
    .free_offset_i    (free_offset_i),
    .status_o         (status_o),
    .granted_offset_o (granted_offset_o),
    .used_blocks_o    (used_blocks_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/bpa_ctrl.sv =====
`default_nettype none

module bpa_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  bpa_pkg::bpa_sts_t   sts_i,
  output bpa_pkg::bpa_cmd_t   cmd_o
);
  import bpa_pkg::*;

  bpa_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.status = RES_OK;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.mode_free) begin
          if (sts_i.bad_off) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = RES_OUT_OF_POOL;
            state_d          = ST_RESP;
          end else begin
            state_d = ST_DIV;
          end
        end else begin
          if (sts_i.bad_size) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = RES_BAD_SIZE;
            state_d          = ST_RESP;
          end else begin
            cmd_o.scan_start = 1'b1;
            state_d          = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_hit) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = RES_OK;
          state_d          = ST_MARK;
        end else if (sts_i.scan_miss) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = RES_NO_ROOM;
          state_d          = ST_RESP;
        end
      end
      ST_MARK: begin
        cmd_o.mark_step = 1'b1;
        if (sts_i.mark_done) begin
          state_d = ST_RESP;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        state_d        = ST_FREE;
      end
      ST_FREE: begin
        cmd_o.free_step = 1'b1;
        if (sts_i.free_done) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = RES_OK;
          state_d          = ST_RESP;
        end
      end
      ST_RESP: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bpa_dp.sv =====
`default_nettype none

module bpa_dp #(
  parameter int unsigned BLOCK_BYTES = bpa_pkg::BLOCK_BYTES_DEF,
  parameter int unsigned BLOCK_COUNT = bpa_pkg::BLOCK_COUNT_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  bpa_pkg::bpa_cmd_t                  cmd_i,
  output bpa_pkg::bpa_sts_t                  sts_o,
  input  wire logic                          mode_i,
  input  wire logic [bpa_pkg::REQ_W-1:0]     request_bytes_i,
  input  wire logic [bpa_pkg::OFF_W-1:0]     free_offset_i,
  output logic [bpa_pkg::STATUS_W-1:0]       status_o,
  output logic [bpa_pkg::GRANT_W-1:0]        granted_offset_o,
  output logic [bpa_pkg::USED_W-1:0]         used_blocks_o
);
  import bpa_pkg::*;

  localparam int unsigned IDX_W      = $clog2(BLOCK_COUNT);
  localparam int unsigned PTR_W      = IDX_W + 1;
  localparam int unsigned CNT_W      = $clog2(BLOCK_COUNT + 1);
  localparam int unsigned POOL_BYTES = BLOCK_BYTES * BLOCK_COUNT;
  localparam int unsigned RB_W       = $clog2(POOL_BYTES + 1);
  localparam int unsigned CMP_W      = (RB_W > REQ_W) ? RB_W : REQ_W;
  localparam int unsigned BB_W       = $clog2(BLOCK_BYTES + 1);
  localparam int unsigned PROD_W     = IDX_W + BB_W;
  localparam int unsigned MK_W       = (CNT_W > ENTRY_W) ? CNT_W : ENTRY_W;
  // offset / BLOCK_BYTES as (offset * DIV_M) >> DIV_SH, exact for any 16-bit offset
  localparam int unsigned DIV_SH     = OFF_W + $clog2(BLOCK_BYTES);
  localparam int unsigned DIV_M_W    = OFF_W + 2;
  localparam int unsigned DIV_P_W    = OFF_W + DIV_M_W;
  localparam longint unsigned DIV_M  =
      ((64'd1 << DIV_SH) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES);

  // owner table
  logic [ENTRY_W-1:0] mem [BLOCK_COUNT];

  logic                 mode_q;
  logic [REQ_W-1:0]     bytes_q;
  logic [OFF_W-1:0]     off_q;
  logic [PTR_W-1:0]     ptr_q, ptr_d;
  logic                 chk_vld_q, chk_vld_d;
  logic [IDX_W-1:0]     chk_idx_q;
  logic [ENTRY_W-1:0]   rd_data_q;
  logic [CNT_W-1:0]     run_q;
  logic [RB_W-1:0]      runb_q;
  logic [IDX_W-1:0]     start_q;
  logic [ENTRY_W-1:0]   mark_q;
  logic [CNT_W-1:0]     wcnt_q;
  logic                 first_q;
  logic [ENTRY_W-1:0]   rlen_q;
  logic [CNT_W-1:0]     used_q;
  bpa_status_e          status_q;
  logic [GRANT_W-1:0]   granted_q;

  logic                 rd_ok;
  logic [IDX_W-1:0]     rd_addr;
  logic                 last_chk;
  logic                 ent_free;
  logic [CNT_W-1:0]     run_n;
  logic [RB_W-1:0]      runb_n;
  logic                 scan_hit;
  logic [PTR_W-1:0]     start_n;
  logic [MK_W-1:0]      run_ext;
  logic [ENTRY_W-1:0]   mark_n;
  logic [ENTRY_W-1:0]   rem_len;
  logic                 free_clr;
  logic                 free_done;
  logic [DIV_P_W-1:0]   div_prod;
  logic [DIV_P_W-1:0]   div_quo;
  logic [PROD_W-1:0]    prod;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [ENTRY_W-1:0]   wr_data;

  assign rd_ok    = ptr_q < PTR_W'(BLOCK_COUNT);
  assign rd_addr  = rd_ok ? ptr_q[IDX_W-1:0] : '0;
  assign last_chk = chk_idx_q == IDX_W'(BLOCK_COUNT - 1);

  // first-fit scan: run length in blocks and in bytes
  assign ent_free = rd_data_q == '0;
  assign run_n    = ent_free ? run_q + CNT_W'(1) : '0;
  assign runb_n   = ent_free ? runb_q + RB_W'(BLOCK_BYTES) : '0;
  assign scan_hit = chk_vld_q && ent_free && (CMP_W'(runb_n) >= CMP_W'(bytes_q));
  assign start_n  = PTR_W'(chk_idx_q) + PTR_W'(1) - PTR_W'(run_n);
  assign run_ext  = MK_W'(run_n);
  assign mark_n   = (run_ext > MK_W'(ENTRY_MAX)) ? ENTRY_W'(ENTRY_MAX) : ENTRY_W'(run_ext);

  // free sweep: first entry read gives the length to clear
  assign rem_len   = first_q ? rd_data_q : rlen_q;
  assign free_clr  = chk_vld_q && (rem_len != '0);
  assign free_done = chk_vld_q && ((rem_len <= ENTRY_W'(1)) || last_chk);

  // offset to block index by constant reciprocal multiply
  assign div_prod = DIV_P_W'(off_q) * DIV_P_W'(DIV_M);
  assign div_quo  = div_prod >> DIV_SH;

  assign prod = PROD_W'(start_q) * PROD_W'(BLOCK_BYTES);

  always_comb begin
    sts_o            = '0;
    sts_o.clear_done = ptr_q == PTR_W'(BLOCK_COUNT - 1);
    sts_o.mode_free  = mode_q == MODE_FREE;
    sts_o.bad_size   = (bytes_q == '0) || (CMP_W'(bytes_q) > CMP_W'(POOL_BYTES));
    sts_o.bad_off    = CMP_W'(off_q) >= CMP_W'(POOL_BYTES);
    sts_o.scan_hit   = scan_hit;
    sts_o.scan_miss  = chk_vld_q && !scan_hit && last_chk;
    sts_o.mark_done  = wcnt_q == CNT_W'(1);
    sts_o.free_done  = free_done;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr_q[IDX_W-1:0];
    wr_data = '0;
    if (cmd_i.clear_step) begin
      wr_en = 1'b1;
    end else if (cmd_i.mark_step) begin
      wr_en   = 1'b1;
      wr_data = mark_q;
    end else if (cmd_i.free_step && free_clr) begin
      wr_en   = 1'b1;
      wr_addr = chk_idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_comb begin
    ptr_d     = ptr_q;
    chk_vld_d = 1'b0;
    if (cmd_i.clear_step || cmd_i.mark_step) begin
      ptr_d = ptr_q + PTR_W'(1);
    end else if (cmd_i.scan_start) begin
      ptr_d = '0;
    end else if (cmd_i.scan_step) begin
      if (scan_hit) begin
        ptr_d = start_n;
      end else if (rd_ok) begin
        ptr_d     = ptr_q + PTR_W'(1);
        chk_vld_d = 1'b1;
      end
    end else if (cmd_i.div_step) begin
      ptr_d = PTR_W'(div_quo);
    end else if (cmd_i.free_step) begin
      if (rd_ok && !free_done) begin
        ptr_d     = ptr_q + PTR_W'(1);
        chk_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q     <= '0;
      chk_vld_q <= 1'b0;
      used_q    <= '0;
      first_q   <= 1'b0;
    end else begin
      ptr_q     <= ptr_d;
      chk_vld_q <= chk_vld_d;
      if (cmd_i.mark_step) begin
        used_q <= used_q + CNT_W'(1);
      end else if (cmd_i.free_step && free_clr && !ent_free) begin
        used_q <= used_q - CNT_W'(1);
      end
      if (cmd_i.div_step) begin
        first_q <= 1'b1;
      end else if (cmd_i.free_step && chk_vld_q) begin
        first_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q <= rd_addr;
    if (cmd_i.load) begin
      mode_q    <= mode_i;
      bytes_q   <= request_bytes_i;
      off_q     <= free_offset_i;
      granted_q <= '0;
    end
    if (cmd_i.scan_start) begin
      run_q  <= '0;
      runb_q <= '0;
    end else if (cmd_i.scan_step && chk_vld_q) begin
      run_q  <= run_n;
      runb_q <= runb_n;
    end
    if (cmd_i.scan_step && scan_hit) begin
      start_q <= start_n[IDX_W-1:0];
      mark_q  <= mark_n;
      wcnt_q  <= run_n;
    end else if (cmd_i.mark_step) begin
      wcnt_q    <= wcnt_q - CNT_W'(1);
      granted_q <= GRANT_W'(prod);
    end
    if (cmd_i.free_step && chk_vld_q) begin
      rlen_q <= rem_len - ENTRY_W'(1);
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status;
    end
  end

  assign status_o         = status_q;
  assign granted_offset_o = granted_q;
  assign used_blocks_o    = USED_W'(used_q);

endmodule

`default_nettype wire
